>>> src/bcomp_pkg.sv
`timescale 1ns / 1ps

package bcomp_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // register indexes, taken from paddr[4:3]
   localparam logic [1:0] REG_CAL_TEMP    = 2'd0;
   localparam logic [1:0] REG_CAL_PRESS_A = 2'd1;
   localparam logic [1:0] REG_CAL_PRESS_B = 2'd2;
   localparam logic [1:0] REG_CAL_PRESS_C = 2'd3;

   // divider: one quotient bit per stage
   localparam int DIV_W = 64;

   // cycles from accepted command to result strobe
   // 9 front stages, 66 divider stages, 4 back stages
   localparam int LATENCY = 79;

   localparam logic signed [33:0] T_FINE_OFFSET = 34'sd128000;
   localparam logic [63:0]        PRESS_FULL    = 64'd1048576;
   localparam logic [63:0]        PRESS_SCALE   = 64'd3125;
   localparam logic signed [63:0] V1_BIAS       = 64'sh0000_8000_0000_0000;

   typedef struct packed {
      logic [19:0] adc_temp;
      logic [19:0] adc_press;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic               press_div_zero;
   } rsp_type;

   // travels alongside a division
   typedef struct packed {
      logic [31:0] temp_centi;
      logic        div_zero;
   } side_type;

endpackage

>>> src/bcomp_div.sv
`timescale 1ns / 1ps

module bcomp_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [bcomp_pkg::DIV_W-1:0] in_num,
   input  logic signed [bcomp_pkg::DIV_W-1:0] in_den,
   input  bcomp_pkg::side_type                in_side,
   output logic                               out_valid,
   output logic signed [bcomp_pkg::DIV_W-1:0] out_quo,
   output bcomp_pkg::side_type                out_side
);

   localparam int W = bcomp_pkg::DIV_W;

   logic [W-1:0]        rem_ff  [W+1];
   logic [W-1:0]        dq_ff   [W+1];
   logic [W-1:0]        dv_ff   [W+1];
   logic                neg_ff  [W+1];
   bcomp_pkg::side_type side_ff [W+1];
   logic                vld_ff  [W+1];

   logic [W-1:0] abs_num_in, abs_den_in;
   logic         neg_in;

   // take magnitudes, remember quotient sign
   always_comb begin
      abs_num_in = in_num[W-1] ? (W'(0) - in_num) : in_num;
      abs_den_in = in_den[W-1] ? (W'(0) - in_den) : in_den;
      neg_in     = in_num[W-1] ^ in_den[W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]  <= '0;
      dq_ff[0]   <= abs_num_in;
      dv_ff[0]   <= abs_den_in;
      neg_ff[0]  <= neg_in;
      side_ff[0] <= in_side;
   end

   // restoring steps, one quotient bit per stage
   for (genvar k = 0; k < W; k++) begin : g_step
      logic [W-1:0] rem_sh, rem_in, dq_in;
      logic         take;

      always_comb begin
         rem_sh = {rem_ff[k][W-2:0], dq_ff[k][W-1]};
         take   = (rem_sh >= dv_ff[k]);
         rem_in = take ? (rem_sh - dv_ff[k]) : rem_sh;
         dq_in  = {dq_ff[k][W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         dq_ff[k+1]   <= dq_in;
         dv_ff[k+1]   <= dv_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   logic [W-1:0]        quo_ff, quo_in;
   logic                out_valid_ff;
   bcomp_pkg::side_type out_side_ff;

   // restore sign
   assign quo_in = neg_ff[W] ? (W'(0) - dq_ff[W]) : dq_ff[W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[W];
      end
      quo_ff      <= quo_in;
      out_side_ff <= side_ff[W];
   end

   assign out_valid = out_valid_ff;
   assign out_quo   = quo_ff;
   assign out_side  = out_side_ff;

endmodule

>>> src/baro_temp_pressure_compensation_top.sv
`timescale 1ns / 1ps

// channel  | handshake           | payload
// command  | start, busy         | req_data  (adc_temp, adc_press)
// result   | rsp_valid (strobe)  | rsp_data  (temperature, pressure, div-zero flag)
// csr      | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// One command is taken every cycle; busy is high only during reset.
// Each result passes through nine front stages, the 64-stage restoring
// divider with its sign stages, and four back stages.
// Reset is synchronous and clears valid bits and calibration registers.
// The result strobe lasts one cycle; the receiver cannot stall it.
module baro_temp_pressure_compensation_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  bcomp_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   output bcomp_pkg::rsp_type                  rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bcomp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bcomp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bcomp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   // ---------------- calibration registers ----------------
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff, cal_press_b_ff;
   logic [15:0] cal_press_c_ff;
   logic [1:0]  csr_index;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:3];
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_press_c_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            bcomp_pkg::REG_CAL_TEMP:    cal_temp_ff    <= pwdata[47:0];
            bcomp_pkg::REG_CAL_PRESS_A: cal_press_a_ff <= pwdata;
            bcomp_pkg::REG_CAL_PRESS_B: cal_press_b_ff <= pwdata;
            bcomp_pkg::REG_CAL_PRESS_C: cal_press_c_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         bcomp_pkg::REG_CAL_TEMP:    prdata = {16'b0, cal_temp_ff};
         bcomp_pkg::REG_CAL_PRESS_A: prdata = cal_press_a_ff;
         bcomp_pkg::REG_CAL_PRESS_B: prdata = cal_press_b_ff;
         bcomp_pkg::REG_CAL_PRESS_C: prdata = {48'b0, cal_press_c_ff};
         default:                    prdata = '0;
      endcase
   end

   // coefficient fields
   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = cal_temp_ff[15:0];
   assign t2 = cal_temp_ff[31:16];
   assign t3 = cal_temp_ff[47:32];
   assign p1 = cal_press_a_ff[15:0];
   assign p2 = cal_press_a_ff[31:16];
   assign p3 = cal_press_a_ff[47:32];
   assign p4 = cal_press_a_ff[63:48];
   assign p5 = cal_press_b_ff[15:0];
   assign p6 = cal_press_b_ff[31:16];
   assign p7 = cal_press_b_ff[47:32];
   assign p8 = cal_press_b_ff[63:48];
   assign p9 = cal_press_c_ff;

   assign busy = reset;

   logic accept;
   assign accept = start & ~busy;

   // ---------------- valid chain of the front stages ----------------
   logic [9:1] vld_ff, vld_in;
   assign vld_in = {vld_ff[8:1], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // carry raw pressure word down to stage 7
   logic [19:0] ap_ff [7:1];

   always_ff @(posedge clock) begin
      ap_ff[1] <= req_data.adc_press;
      for (int i = 2; i <= 7; i++) begin
         ap_ff[i] <= ap_ff[i-1];
      end
   end

   // stage 1: temperature products
   logic [31:0] ta, td, a_in, dd_in, a_ff, dd_ff;

   always_comb begin
      ta    = 32'(req_data.adc_temp >> 3) - {15'b0, t1, 1'b0};
      td    = 32'(req_data.adc_temp >> 4) - {16'b0, t1};
      a_in  = ta * {{16{t2[15]}}, t2};
      dd_in = td * td;
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      dd_ff <= dd_in;
   end

   // stage 2
   logic [31:0] tv1_in, x_in, tv1_ff, x_ff, dsh;

   always_comb begin
      dsh    = 32'($signed(dd_ff) >>> 12);
      tv1_in = 32'($signed(a_ff) >>> 11);
      x_in   = dsh * {{16{t3[15]}}, t3};
   end

   always_ff @(posedge clock) begin
      tv1_ff <= tv1_in;
      x_ff   <= x_in;
   end

   // stage 3: fine temperature
   logic [31:0] fine_in, fine_ff;
   assign fine_in = tv1_ff + 32'($signed(x_ff) >>> 14);

   always_ff @(posedge clock) begin
      fine_ff <= fine_in;
   end

   // stage 4: temperature result and pressure offset
   logic [31:0]        fm, temp_in;
   logic signed [33:0] v1_in, v1_ff;
   logic [31:0]        temp_ff [9:4];

   always_comb begin
      fm      = fine_ff * 32'd5 + 32'd128;
      temp_in = 32'($signed(fm) >>> 8);
      v1_in   = $signed({{2{fine_ff[31]}}, fine_ff}) - bcomp_pkg::T_FINE_OFFSET;
   end

   always_ff @(posedge clock) begin
      temp_ff[4] <= temp_in;
      v1_ff      <= v1_in;
      for (int i = 5; i <= 9; i++) begin
         temp_ff[i] <= temp_ff[i-1];
      end
   end

   // stage 5: square and linear terms
   logic signed [67:0] v1sq;
   logic signed [63:0] sq_in, m5_in, m2_in, sq_ff, m5_ff, m2_ff;

   always_comb begin
      v1sq  = v1_ff * v1_ff;
      sq_in = v1sq[63:0];
      m5_in = v1_ff * p5;
      m2_in = v1_ff * p2;
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
      m5_ff <= m5_in;
      m2_ff <= m2_in;
   end

   // stage 6: quadratic terms
   logic signed [79:0] sq_p6, sq_p3;
   logic signed [63:0] v2a_ff, m3_ff, m5b_ff, m2b_ff;

   always_comb begin
      sq_p6 = sq_ff * p6;
      sq_p3 = sq_ff * p3;
   end

   always_ff @(posedge clock) begin
      v2a_ff <= sq_p6[63:0];
      m3_ff  <= sq_p3[63:0];
      m5b_ff <= m5_ff;
      m2b_ff <= m2_ff;
   end

   // stage 7: sum the terms
   logic signed [63:0] v2_in, s_in, v2_ff, s_ff, v1b;

   always_comb begin
      v2_in = v2a_ff + (m5b_ff <<< 17) + (64'(p4) <<< 35);
      v1b   = (m3_ff >>> 8) + (m2b_ff <<< 12);
      s_in  = bcomp_pkg::V1_BIAS + v1b;
   end

   always_ff @(posedge clock) begin
      v2_ff <= v2_in;
      s_ff  <= s_in;
   end

   // stage 8: divisor product and numerator base
   logic signed [79:0] s_p1;
   logic [63:0]        pp, numa_in, numa_ff;
   logic signed [63:0] prod_ff;

   always_comb begin
      s_p1    = s_ff * $signed({1'b0, p1});
      pp      = bcomp_pkg::PRESS_FULL - 64'(ap_ff[7]);
      numa_in = (pp << 31) - v2_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= s_p1[63:0];
      numa_ff <= numa_in;
   end

   // stage 9: divisor, numerator, zero check
   logic signed [63:0] num_in, den_in, num_ff, den_ff;
   logic               dz_in, dz_ff;

   always_comb begin
      num_in = numa_ff * bcomp_pkg::PRESS_SCALE;
      den_in = prod_ff >>> 33;
      dz_in  = (prod_ff[63:33] == '0);
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      dz_ff  <= dz_in;
   end

   // ---------------- divider ----------------
   bcomp_pkg::side_type div_side_in, div_side;
   logic                div_valid;
   logic signed [63:0]  quo;

   assign div_side_in.temp_centi = temp_ff[9];
   assign div_side_in.div_zero   = dz_ff;

   bcomp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[9]),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (div_side_in),
      .out_valid (div_valid),
      .out_quo   (quo),
      .out_side  (div_side)
   );

   // ---------------- back stages ----------------
   logic [3:1]          bv_ff, bv_in;
   bcomp_pkg::side_type bs_ff [3:1];
   logic signed [63:0]  q_ff [3:1];
   logic signed [63:0]  m8_ff [3:1];

   assign bv_in = {bv_ff[2:1], div_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
      end else begin
         bv_ff <= bv_in;
      end
      bs_ff[1] <= div_side;
      q_ff[1]  <= quo;
      for (int i = 2; i <= 3; i++) begin
         bs_ff[i] <= bs_ff[i-1];
         q_ff[i]  <= q_ff[i-1];
         m8_ff[i] <= m8_ff[i-1];
      end
   end

   // back 1: split square of p >> 13, P8 term
   logic signed [63:0] ph;
   logic signed [79:0] q_p8;
   logic [63:0]        ll_in, ll_ff;
   logic [31:0]        hl_in, hl_ff;

   always_comb begin
      ph    = quo >>> 13;
      q_p8  = quo * p8;
      ll_in = 64'(ph[31:0]) * 64'(ph[31:0]);
      hl_in = ph[63:32] * ph[31:0];
   end

   always_ff @(posedge clock) begin
      m8_ff[1] <= q_p8[63:0];
      ll_ff    <= ll_in;
      hl_ff    <= hl_in;
   end

   // back 2: join partial products
   logic signed [63:0] sq2_ff;

   always_ff @(posedge clock) begin
      sq2_ff <= ll_ff + {hl_ff[30:0], 33'b0};
   end

   // back 3: P9 term
   logic signed [79:0] sq2_p9;
   logic signed [63:0] m9_ff;
   assign sq2_p9 = sq2_ff * p9;

   always_ff @(posedge clock) begin
      m9_ff <= sq2_p9[63:0];
   end

   // back 4: final pressure into the result register
   logic signed [63:0] psum, pfin;
   bcomp_pkg::rsp_type rsp_in, rsp_ff;
   logic               rsp_valid_ff;

   always_comb begin
      psum                     = q_ff[3] + (m9_ff >>> 25) + (m8_ff[3] >>> 19);
      pfin                     = (psum >>> 8) + (64'(p7) <<< 4);
      rsp_in.temperature_centi = bs_ff[3].temp_centi;
      rsp_in.press_div_zero    = bs_ff[3].div_zero;
      rsp_in.pressure_q24_8    = bs_ff[3].div_zero ? 32'd0 : pfin[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= bv_ff[3];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(bcomp_pkg::LATENCY) rsp_valid)
      else $error("result strobe missing after fixed latency");

   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.press_div_zero |-> rsp_data.pressure_q24_8 == 32'd0)
      else $error("pressure not zero on zero divisor");

   a_div_align : assert property (@(posedge clock) disable iff (reset)
      vld_ff[9] |-> ##(bcomp_pkg::DIV_W + 2) div_valid)
      else $error("divider lost a word");

endmodule

>>> dv/baro_comp_checker.sv
`timescale 1ns / 1ps

module baro_comp_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  bcomp_pkg::req_type                 req_data,
   input  logic                               rsp_valid,
   input  bcomp_pkg::rsp_type                 rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic                               pready,
   input  logic [bcomp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bcomp_pkg::CSR_DATA_W-1:0]   pwdata,
   output int                                 fails,
   output int                                 pending
);

   // shadow calibration registers
   logic [47:0] cal_t;
   logic [63:0] cal_pa;
   logic [63:0] cal_pb;
   logic [15:0] cal_pc;

   bcomp_pkg::rsp_type readings_due[$];

   function automatic logic [31:0] sra32(logic [31:0] x, int n);
      logic signed [31:0] s;
      s = x;
      return s >>> n;
   endfunction

   function automatic logic [63:0] sra64(logic [63:0] x, int n);
      logic signed [63:0] s;
      s = x;
      return s >>> n;
   endfunction

   function automatic logic [63:0] sx16(logic [15:0] f);
      return {{48{f[15]}}, f};
   endfunction

   // signed divide truncating toward zero, wrapping on overflow
   function automatic logic [63:0] quot64(logic [63:0] n, logic [63:0] d);
      logic [63:0] mn, md, q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q = mn / md;
      return (n[63] != d[63]) ? -q : q;
   endfunction

   function automatic bcomp_pkg::rsp_type compensate(bcomp_pkg::req_type r);
      logic [31:0] t, t1, t2, t3, a, tv1, d, m, tv2, fine, tmp;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] v1, v2, x, y, ap, p, q, ph, w1, w2;
      bcomp_pkg::rsp_type o;
      t  = {12'd0, r.adc_temp};
      t1 = {16'd0, cal_t[15:0]};
      t2 = 32'(sx16(cal_t[31:16]));
      t3 = 32'(sx16(cal_t[47:32]));
      p1 = {48'd0, cal_pa[15:0]};
      p2 = sx16(cal_pa[31:16]);
      p3 = sx16(cal_pa[47:32]);
      p4 = sx16(cal_pa[63:48]);
      p5 = sx16(cal_pb[15:0]);
      p6 = sx16(cal_pb[31:16]);
      p7 = sx16(cal_pb[47:32]);
      p8 = sx16(cal_pb[63:48]);
      p9 = sx16(cal_pc);
      // temperature, 32-bit wrap
      a    = ((t >> 3) - (t1 << 1)) * t2;
      tv1  = sra32(a, 11);
      d    = (t >> 4) - t1;
      m    = sra32(d * d, 12);
      tv2  = sra32(m * t3, 14);
      fine = tv1 + tv2;
      tmp  = fine * 32'd5 + 32'd128;
      o.temperature_centi = sra32(tmp, 8);
      // pressure, 64-bit wrap
      v1 = {{32{fine[31]}}, fine} - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      x  = sra64(v1 * v1 * p3, 8);
      y  = (v1 * p2) << 12;
      v1 = x + y;
      v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
      o.pressure_q24_8 = '0;
      o.press_div_zero = 1'b0;
      if (v1 == 64'd0) begin
         o.press_div_zero = 1'b1;
      end else begin
         ap = {44'd0, r.adc_press};
         p  = 64'd1048576 - ap;
         q  = quot64(((p << 31) - v2) * 64'd3125, v1);
         ph = sra64(q, 13);
         w1 = sra64(p9 * ph * ph, 25);
         w2 = sra64(p8 * q, 19);
         p  = sra64(q + w1 + w2, 8) + (p7 << 4);
         o.pressure_q24_8 = p[31:0];
      end
      return o;
   endfunction

   task automatic report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
   endtask

   assign pending = readings_due.size();

   // track register writes, predict accepted words, compare results
   always @(posedge clock) begin
      bcomp_pkg::rsp_type want;
      if (reset) begin
         cal_t  <= '0;
         cal_pa <= '0;
         cal_pb <= '0;
         cal_pc <= '0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               bcomp_pkg::REG_CAL_TEMP:    cal_t  <= pwdata[47:0];
               bcomp_pkg::REG_CAL_PRESS_A: cal_pa <= pwdata;
               bcomp_pkg::REG_CAL_PRESS_B: cal_pb <= pwdata;
               bcomp_pkg::REG_CAL_PRESS_C: cal_pc <= pwdata[15:0];
               default: ;
            endcase
         end
         if (start && !busy)
            readings_due.push_back(compensate(req_data));
         if (rsp_valid) begin
            if (readings_due.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               want = readings_due.pop_front();
               if (rsp_data.temperature_centi !== want.temperature_centi)
                  report($sformatf("temperature got %0d want %0d",
                     rsp_data.temperature_centi, want.temperature_centi));
               if (rsp_data.pressure_q24_8 !== want.pressure_q24_8)
                  report($sformatf("pressure got %h want %h",
                     rsp_data.pressure_q24_8, want.pressure_q24_8));
               if (rsp_data.press_div_zero !== want.press_div_zero)
                  report($sformatf("div-zero flag got %b want %b",
                     rsp_data.press_div_zero, want.press_div_zero));
            end
         end
      end
   end

endmodule

>>> dv/baro_temp_pressure_compensation_top_tb.sv
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_top_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int WORDS_PER_PHASE = 240;
   localparam int PHASES = 8;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   bcomp_pkg::req_type               req_data;
   logic                             rsp_valid;
   bcomp_pkg::rsp_type               rsp_data;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [bcomp_pkg::CSR_ADDR_W-1:0] paddr;
   logic [bcomp_pkg::CSR_DATA_W-1:0] pwdata;
   logic [bcomp_pkg::CSR_DATA_W-1:0] prdata;
   logic                             pready;
   int                               fails;
   int                               pending;
   int                               cycles;

   baro_temp_pressure_compensation_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   baro_comp_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // hold the word until accepted, then idle for the gap
   task automatic send_word(logic [19:0] at, logic [19:0] ap, int gap);
      start <= 1'b1;
      req_data <= '{adc_temp: at, adc_press: ap};
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [1:0] idx, logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= bcomp_pkg::CSR_ADDR_W'({idx, 3'b000});
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // let every result drain before touching the registers
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (bcomp_pkg::LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [19:0] pick_adc(logic [19:0] centre);
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 20'($urandom);
      if (r < 8) return centre + 20'($urandom_range(0, 8191)) - 20'd4096;
      if (r == 8) return 20'hFFFFF - 20'($urandom_range(0, 3));
      return 20'($urandom_range(0, 3));
   endfunction

   initial begin
      logic [63:0] ct, pa, pb, pc;
      logic [19:0] at_list [10];
      logic [19:0] ap_list [10];
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      at_list = '{20'd0, 20'hFFFFF, 20'd519888, 20'hAAAAA, 20'h55555,
                  20'd440064, 20'd0, 20'hFFFFF, 20'd519888, 20'd600000};
      ap_list = '{20'd0, 20'hFFFFF, 20'd415148, 20'h55555, 20'hAAAAA,
                  20'd0, 20'hFFFFF, 20'd0, 20'hFFFFF, 20'd300000};
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            drain();
            case (ph)
               1: begin
                  // typical sensor calibration
                  ct = {16'($urandom), 16'hFC18, 16'd26435, 16'd27504};
                  pa = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
                  pb = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
                  pc = {$urandom, 16'($urandom), 16'd6000};
               end
               2: begin
                  ct = '1; pa = '1; pb = '1; pc = '1;
               end
               3: begin
                  ct = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
                  pa = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
                  pb = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
                  pc = 64'h7FFF;
               end
               4: begin
                  ct = {16'h0, 16'h8000, 16'h8000, 16'h0};
                  pa = {16'h8000, 16'h8000, 16'h8000, 16'h0001};
                  pb = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
                  pc = 64'h8000;
               end
               5: begin
                  // zero P1 forces the zero-divisor path
                  ct = {$urandom, $urandom};
                  pa = {$urandom, 16'($urandom), 16'h0};
                  pb = {$urandom, $urandom};
                  pc = {$urandom, $urandom};
               end
               default: begin
                  ct = {$urandom, $urandom};
                  pa = {$urandom, $urandom};
                  pb = {$urandom, $urandom};
                  pc = {$urandom, $urandom};
               end
            endcase
            csr_write(bcomp_pkg::REG_CAL_TEMP, ct);
            csr_write(bcomp_pkg::REG_CAL_PRESS_A, pa);
            csr_write(bcomp_pkg::REG_CAL_PRESS_B, pb);
            csr_write(bcomp_pkg::REG_CAL_PRESS_C, pc);
         end
         // directed extremes in each phase
         for (int i = 0; i < 10; i++)
            send_word(at_list[i], ap_list[i], (i % 3 == 0) ? 0 : pick_gap());
         // random words, with a stretch of back-to-back traffic
         for (int i = 0; i < WORDS_PER_PHASE; i++)
            send_word(pick_adc(20'd519888), pick_adc(20'd415148),
                      (i >= 100 && i < 140) ? 0 : pick_gap());
      end
      drain();
      if (fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
